[design/pqes_pkg.sv]
`default_nettype none
package pqes_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TRIG_STEPS = 16;

  // angle reduction: |theta| in unsigned Q16.30, one conditional subtract of 2pi*2^k per cycle
  localparam int MAG_W     = 62 - FRAC_BITS;
  localparam int RED_STEPS = MAG_W - 32;
  localparam int RED_CW    = $clog2(RED_STEPS);
  localparam int ROT_CW    = $clog2(TRIG_STEPS);

  localparam int RW = 36;   // CORDIC word
  localparam int MW = 34;   // multiplier operand
  localparam int PW = 2 * MW;
  localparam int SW = PW + 2;

  localparam logic [33:0]          TWO_PI_U    = 34'd6746518852;
  localparam logic signed [RW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [RW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [RW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [RW-1:0] Q30_GAIN    = 36'sd652032874;

  localparam logic [63:0] MOVE_THR = 64'((65'd1 << (2 * FRAC_BITS)) / 10000);

  typedef enum logic [2:0] {
    REG_INV_MASS, REG_ARM_OVER_INERTIA, REG_GRAVITY, REG_TIME_STEP,
    REG_INITIAL_X, REG_INITIAL_Y, REG_INITIAL_ANGLE
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED, ST_FOLD, ST_ROT, ST_MISS, ST_MWB, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_SIN1, OP_SIN2, OP_COS1, OP_COS2, OP_ANG,
    OP_SQ_VX, OP_SQ_VY, OP_SQ_W, OP_SQ_AX, OP_SQ_AY, OP_SQ_AW,
    OP_UP_PX, OP_UP_PY, OP_UP_AN, OP_UP_VX, OP_UP_VY, OP_UP_W
  } mop_t;

  typedef struct packed {
    logic              load_in;
    logic              red_step;
    logic [RED_CW-1:0] red_k;
    logic              fold;
    logic              rot_step;
    logic [ROT_CW-1:0] rot_i;
    logic              mul_iss;
    logic              mul_wb;
    mop_t              mop;
    logic              out_load;
  } dp_cmd_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(SW'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
    else if (v < $signed(SW'(-33'sh80000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[design/pqes_ctrl.sv]
`default_nettype none
module pqes_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_restart,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pqes_pkg::dp_cmd_t      cmd
);

  pqes_pkg::state_t                state_r, state_nxt;
  logic [pqes_pkg::RED_CW-1:0]     red_k_r;
  logic [pqes_pkg::ROT_CW-1:0]     rot_i_r;
  pqes_pkg::mop_t                  mop_r;
  logic                            out_valid_r;
  logic                            accept;
  logic                            slot_free;

  assign in_ready  = (state_r == pqes_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pqes_pkg::ST_IDLE: begin
        if (accept) state_nxt = in_restart ? pqes_pkg::ST_FIN : pqes_pkg::ST_RED;
      end
      pqes_pkg::ST_RED: begin
        if (red_k_r == '0) state_nxt = pqes_pkg::ST_FOLD;
      end
      pqes_pkg::ST_FOLD: state_nxt = pqes_pkg::ST_ROT;
      pqes_pkg::ST_ROT: begin
        if (rot_i_r == pqes_pkg::ROT_CW'(pqes_pkg::TRIG_STEPS - 1))
          state_nxt = pqes_pkg::ST_MISS;
      end
      pqes_pkg::ST_MISS: state_nxt = pqes_pkg::ST_MWB;
      pqes_pkg::ST_MWB: begin
        state_nxt = (mop_r == pqes_pkg::OP_UP_W) ? pqes_pkg::ST_FIN : pqes_pkg::ST_MISS;
      end
      pqes_pkg::ST_FIN: begin
        if (slot_free) state_nxt = pqes_pkg::ST_IDLE;
      end
      default: state_nxt = pqes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.red_k    = red_k_r;
    cmd.rot_i    = rot_i_r;
    cmd.mop      = mop_r;
    cmd.load_in  = accept;
    cmd.red_step = (state_r == pqes_pkg::ST_RED);
    cmd.fold     = (state_r == pqes_pkg::ST_FOLD);
    cmd.rot_step = (state_r == pqes_pkg::ST_ROT);
    cmd.mul_iss  = (state_r == pqes_pkg::ST_MISS);
    cmd.mul_wb   = (state_r == pqes_pkg::ST_MWB);
    cmd.out_load = (state_r == pqes_pkg::ST_FIN) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pqes_pkg::ST_IDLE;
      red_k_r     <= '0;
      rot_i_r     <= '0;
      mop_r       <= pqes_pkg::OP_SIN1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pqes_pkg::ST_IDLE) begin
        red_k_r <= pqes_pkg::RED_CW'(pqes_pkg::RED_STEPS - 1);
        rot_i_r <= '0;
        mop_r   <= pqes_pkg::OP_SIN1;
      end
      if (state_r == pqes_pkg::ST_RED) red_k_r <= red_k_r - 1'b1;
      if (state_r == pqes_pkg::ST_ROT) rot_i_r <= rot_i_r + 1'b1;
      if (state_r == pqes_pkg::ST_MWB && mop_r != pqes_pkg::OP_UP_W)
        mop_r <= pqes_pkg::mop_t'(mop_r + 5'd1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[design/pqes_dp.sv]
`default_nettype none
module pqes_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pqes_pkg::dp_cmd_t  cmd,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_addr,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic signed [31:0] thrust_left,
  input  wire logic signed [31:0] thrust_right,
  input  wire logic               restart,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      angle_o,
  output logic signed [31:0]      vel_x_o,
  output logic signed [31:0]      vel_y_o,
  output logic signed [31:0]      ang_vel_o,
  output logic                    moving_o
);

  localparam int RW    = pqes_pkg::RW;
  localparam int MW    = pqes_pkg::MW;
  localparam int PW    = pqes_pkg::PW;
  localparam int SW    = pqes_pkg::SW;
  localparam int MAG_W = pqes_pkg::MAG_W;
  localparam int FB    = pqes_pkg::FRAC_BITS;

  logic [30:0]        inv_mass_r, aoi_r, gravity_r, tstep_r;
  logic signed [31:0] init_x_r, init_y_r, init_an_r;

  logic signed [31:0] px_r, py_r, an_r, vx_r, vy_r, w_r;
  logic signed [31:0] sum_r, diff_r, t_r, ax_r, ay_r, aw_r;
  logic [MAG_W-1:0]   mag_r;
  logic               neg_th_r, flip_r;
  logic signed [RW-1:0] r_r, x_r, y_r;
  logic signed [PW-1:0] prod_r;
  logic [63:0]        acc_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r <= 31'd65536;
      aoi_r      <= 31'd65536;
      gravity_r  <= 31'd642908;
      tstep_r    <= 31'd655;
      init_x_r   <= '0;
      init_y_r   <= '0;
      init_an_r  <= '0;
    end else if (cfg_we) begin
      unique case (pqes_pkg::reg_idx_t'(cfg_addr))
        pqes_pkg::REG_INV_MASS:         inv_mass_r <= cfg_wdata[30:0];
        pqes_pkg::REG_ARM_OVER_INERTIA: aoi_r      <= cfg_wdata[30:0];
        pqes_pkg::REG_GRAVITY:          gravity_r  <= cfg_wdata[30:0];
        pqes_pkg::REG_TIME_STEP:        tstep_r    <= cfg_wdata[30:0];
        pqes_pkg::REG_INITIAL_X:        init_x_r   <= cfg_wdata;
        pqes_pkg::REG_INITIAL_Y:        init_y_r   <= cfg_wdata;
        pqes_pkg::REG_INITIAL_ANGLE:    init_an_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input capture
  logic [32:0]        th_abs;
  logic signed [31:0] sum_nxt, diff_nxt;
  assign th_abs   = an_r[31] ? 33'(-$signed({an_r[31], an_r})) : {1'b0, an_r};
  assign sum_nxt  = pqes_pkg::sat32(SW'(thrust_left) + SW'(thrust_right));
  assign diff_nxt = pqes_pkg::sat32(SW'(thrust_left) - SW'(thrust_right));

  // reduction step
  logic [MAG_W:0] tw;
  assign tw = (MAG_W + 1)'(pqes_pkg::TWO_PI_U) << cmd.red_k;

  // fold into [-pi/2, pi/2]
  logic signed [RW-1:0] f0, f1, f2;
  logic                 f_flip;
  always_comb begin
    f0 = neg_th_r ? -RW'(mag_r) : RW'(mag_r);
    f1 = f0;
    if (f0 > pqes_pkg::Q30_PI) f1 = f0 - pqes_pkg::Q30_TWO_PI;
    else if (f0 < -pqes_pkg::Q30_PI) f1 = f0 + pqes_pkg::Q30_TWO_PI;
    f2     = f1;
    f_flip = 1'b0;
    if (f1 > pqes_pkg::Q30_HALF_PI) begin
      f2     = f1 - pqes_pkg::Q30_PI;
      f_flip = 1'b1;
    end else if (f1 < -pqes_pkg::Q30_HALF_PI) begin
      f2     = f1 + pqes_pkg::Q30_PI;
      f_flip = 1'b1;
    end
  end

  // CORDIC iteration
  logic signed [RW-1:0] xs, ys, at;
  assign xs = x_r >>> cmd.rot_i;
  assign ys = y_r >>> cmd.rot_i;
  assign at = $signed(RW'(pqes_pkg::atan_q30(5'(cmd.rot_i))));

  logic signed [RW-1:0] sn, cs;
  assign sn = flip_r ? -y_r : y_r;
  assign cs = flip_r ? -x_r : x_r;

  // shared multiplier operands
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] ts_op, inv_op;
  assign ts_op  = $signed(MW'({1'b0, tstep_r}));
  assign inv_op = $signed(MW'({1'b0, inv_mass_r}));

  always_comb begin
    mul_a = MW'(sum_r);
    mul_b = MW'(sn);
    unique case (cmd.mop)
      pqes_pkg::OP_SIN1:  begin mul_a = MW'(sum_r);  mul_b = MW'(sn); end
      pqes_pkg::OP_SIN2:  begin mul_a = MW'(t_r);    mul_b = inv_op; end
      pqes_pkg::OP_COS1:  begin mul_a = MW'(sum_r);  mul_b = MW'(cs); end
      pqes_pkg::OP_COS2:  begin mul_a = MW'(t_r);    mul_b = inv_op; end
      pqes_pkg::OP_ANG:   begin
        mul_a = MW'(diff_r);
        mul_b = $signed(MW'({1'b0, aoi_r}));
      end
      pqes_pkg::OP_SQ_VX: begin mul_a = MW'(vx_r); mul_b = MW'(vx_r); end
      pqes_pkg::OP_SQ_VY: begin mul_a = MW'(vy_r); mul_b = MW'(vy_r); end
      pqes_pkg::OP_SQ_W:  begin mul_a = MW'(w_r);  mul_b = MW'(w_r);  end
      pqes_pkg::OP_SQ_AX: begin mul_a = MW'(ax_r); mul_b = MW'(ax_r); end
      pqes_pkg::OP_SQ_AY: begin mul_a = MW'(ay_r); mul_b = MW'(ay_r); end
      pqes_pkg::OP_SQ_AW: begin mul_a = MW'(aw_r); mul_b = MW'(aw_r); end
      pqes_pkg::OP_UP_PX: begin mul_a = MW'(vx_r); mul_b = ts_op; end
      pqes_pkg::OP_UP_PY: begin mul_a = MW'(vy_r); mul_b = ts_op; end
      pqes_pkg::OP_UP_AN: begin mul_a = MW'(w_r);  mul_b = ts_op; end
      pqes_pkg::OP_UP_VX: begin mul_a = MW'(ax_r); mul_b = ts_op; end
      pqes_pkg::OP_UP_VY: begin mul_a = MW'(ay_r); mul_b = ts_op; end
      pqes_pkg::OP_UP_W:  begin mul_a = MW'(aw_r); mul_b = ts_op; end
      default: ;
    endcase
  end

  // writeback terms
  logic signed [SW-1:0] shf_f, shf_30;
  logic signed [31:0]   sat_f, sat_30;
  logic [64:0]          acc_sum;
  assign shf_f   = SW'(prod_r >>> FB);
  assign shf_30  = SW'(prod_r >>> 30);
  assign sat_f   = pqes_pkg::sat32(shf_f);
  assign sat_30  = pqes_pkg::sat32(shf_30);
  assign acc_sum = {1'b0, acc_r} + {1'b0, prod_r[63:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      an_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
      w_r  <= '0;
    end else begin
      if (cmd.load_in && restart) begin
        px_r <= init_x_r;
        py_r <= init_y_r;
        an_r <= init_an_r;
        vx_r <= '0;
        vy_r <= '0;
        w_r  <= '0;
      end
      if (cmd.mul_wb) begin
        unique case (cmd.mop)
          pqes_pkg::OP_UP_PX: px_r <= pqes_pkg::sat32(SW'(px_r) + shf_f);
          pqes_pkg::OP_UP_PY: py_r <= pqes_pkg::sat32(SW'(py_r) + shf_f);
          pqes_pkg::OP_UP_AN: an_r <= pqes_pkg::sat32(SW'(an_r) + shf_f);
          pqes_pkg::OP_UP_VX: vx_r <= pqes_pkg::sat32(SW'(vx_r) + shf_f);
          pqes_pkg::OP_UP_VY: vy_r <= pqes_pkg::sat32(SW'(vy_r) + shf_f);
          pqes_pkg::OP_UP_W:  w_r  <= pqes_pkg::sat32(SW'(w_r) + shf_f);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sum_r    <= sum_nxt;
      diff_r   <= diff_nxt;
      mag_r    <= MAG_W'(th_abs) << (30 - FB);
      neg_th_r <= an_r[31];
      acc_r    <= '0;
    end
    if (cmd.red_step && ({1'b0, mag_r} >= tw)) mag_r <= mag_r - tw[MAG_W-1:0];
    if (cmd.fold) begin
      r_r    <= f2;
      flip_r <= f_flip;
      x_r    <= pqes_pkg::Q30_GAIN;
      y_r    <= '0;
    end
    if (cmd.rot_step) begin
      if (r_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        r_r <= r_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        r_r <= r_r + at;
      end
    end
    if (cmd.mul_iss) prod_r <= mul_a * mul_b;
    if (cmd.mul_wb) begin
      unique case (cmd.mop)
        pqes_pkg::OP_SIN1, pqes_pkg::OP_COS1: t_r <= sat_30;
        pqes_pkg::OP_SIN2: ax_r <= pqes_pkg::sat32(-SW'(sat_f));
        pqes_pkg::OP_COS2: ay_r <= pqes_pkg::sat32(SW'(sat_f) - $signed(SW'({1'b0, gravity_r})));
        pqes_pkg::OP_ANG:  aw_r <= sat_f;
        pqes_pkg::OP_SQ_VX, pqes_pkg::OP_SQ_VY, pqes_pkg::OP_SQ_W,
        pqes_pkg::OP_SQ_AX, pqes_pkg::OP_SQ_AY, pqes_pkg::OP_SQ_AW:
          acc_r <= acc_sum[64] ? '1 : acc_sum[63:0];
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      pos_x_o   <= px_r;
      pos_y_o   <= py_r;
      angle_o   <= an_r;
      vel_x_o   <= vx_r;
      vel_y_o   <= vy_r;
      ang_vel_o <= w_r;
      moving_o  <= (acc_r > pqes_pkg::MOVE_THR);
    end
  end

endmodule
`default_nettype wire

[design/planar_quadrotor_euler_step.sv]
// Planar quadrotor plant: one forward Euler step per non-restart input beat.
// Input channel (in_valid/in_ready): thrust_left, thrust_right and restart.
// Result channel (out_valid/out_ready): new pose, velocities and moving flag,
// one result beat per input beat, in order.
// Config channel (cfg_valid/cfg_ready): cfg_index selects the register,
// cfg_data the value; always ready; indexes past the list are dropped.
// Write config only while idle.
// A restart beat goes from acceptance straight to the finish state. A step
// beat at Q16.16 passes through angle reduction, the fold, the CORDIC iterations,
// the shared multiplier (17 products, each an issue and a writeback) and
// the finish state before out_valid rises.
// One beat is in flight at a time; in_ready returns together with out_valid,
// so no beat is accepted until the previous one has left the finish state.
// The sequential CORDIC and the one shared multiplier keep it to one beat.
// Reset (rst_n low, synchronous) restores the config defaults, zeroes the
// state and drops any pending result.
// A stalled receiver holds the result in the output register; the next beat
// may be accepted and computed meanwhile, and waits in the finish state until
// the output register frees.
`default_nettype none
module planar_quadrotor_euler_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_thrust_left,
  input  wire logic signed [31:0] in_thrust_right,
  input  wire logic               in_restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x_out,
  output logic signed [31:0]      out_pos_y_out,
  output logic signed [31:0]      out_angle_out,
  output logic signed [31:0]      out_vel_x_out,
  output logic signed [31:0]      out_vel_y_out,
  output logic signed [31:0]      out_ang_vel_out,
  output logic                    out_moving,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  pqes_pkg::dp_cmd_t cmd;

  // config writes land directly in the datapath registers
  assign cfg_ready = 1'b1;

  pqes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  pqes_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_addr     (cfg_index),
    .cfg_wdata    (cfg_data),
    .thrust_left  (in_thrust_left),
    .thrust_right (in_thrust_right),
    .restart      (in_restart),
    .pos_x_o      (out_pos_x_out),
    .pos_y_o      (out_pos_y_out),
    .angle_o      (out_angle_out),
    .vel_x_o      (out_vel_x_out),
    .vel_y_o      (out_vel_y_out),
    .ang_vel_o    (out_ang_vel_out),
    .moving_o     (out_moving)
  );

endmodule
`default_nettype wire

[design/pqes_checker.sv]
`default_nettype none
module pqes_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pos_x_out,
  input wire logic [31:0] out_vel_x_out
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x_out)
                                && $stable(out_vel_x_out))
    else $error("result dropped or changed under stall");

  // one beat in flight
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // vacuous; the antecedent already requires !out_valid
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(in_ready) && in_ready |-> !out_valid)
    else $error("result without an input beat");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind planar_quadrotor_euler_step pqes_checker u_pqes_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x_out (out_pos_x_out),
  .out_vel_x_out (out_vel_x_out)
);
`default_nettype wire
